### src/mft_pkg.sv
`default_nettype none
package mft_pkg;

  localparam int COUNTS_PER_REV = 8192;
  localparam int POS_W          = $clog2(COUNTS_PER_REV);
  localparam int HALF_REV       = COUNTS_PER_REV / 2;

  localparam int TURN_W  = 32;
  localparam int MTP_W   = 32;
  localparam int SPEED_W = 16;
  localparam int CUR_W   = 16;
  localparam int TEMP_W  = 8;
  localparam int GAIN_W  = 16;
  localparam int SPQ_W   = 32;

  localparam int ANGLE_SCALE   = 411775;
  localparam int ANGLE_SCALE_W = 20;
  localparam int ANGLE_W       = 41;
  localparam int ANGLE_PROD_W  = MTP_W + ANGLE_SCALE_W;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POS_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 1'd1;

  localparam logic [GAIN_W-1:0] SPEED_GAIN_RESET = 16'd6863;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic                     link;
    logic [TURN_W-1:0]        turns;
    logic [POS_W-1:0]         last_pos;
    logic signed [SPEED_W-1:0] speed;
    logic signed [CUR_W-1:0]  current;
    logic [TEMP_W-1:0]        temp;
  } trk_state_t;

endpackage
`default_nettype wire

### src/motor_feedback_multiturn_tracker.sv
// Multi-turn encoder tracker with link watchdog.
// Input channel (in_valid / in_stall): one beat is either a feedback frame
// (in_cmd low: encoder position, speed, current, temperature) or a watchdog
// tick (in_cmd high, data ignored). Every accepted beat yields exactly one
// result beat on the output channel (out_valid / out_stall) carrying link
// state, wrapping multi-turn position, Q25.16 angle, Q16.16 speed, and the
// held current and temperature.
// Throughput: one beat per cycle while no stall holds the output; the path
// is a state-update stage, an offset-add and speed-multiply stage, and an
// angle-multiply stage feeding the output register.
// Stall: a stalled result holds in the output register; the earlier stages
// keep filling until each holds a beat, after which in_stall rises.
// Configuration (cfg_we / cfg_index / cfg_wdata): index 0 is the position
// offset, index 1 the rpm-to-rad/s gain; write only while the block is idle.
// Reset (rst_n low, synchronous): turn count, position and held data clear,
// link goes down, offset clears, gain returns to 2*pi/60 in Q0.16.
`default_nettype none
module motor_feedback_multiturn_tracker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [mft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_cmd,
  input  wire logic [mft_pkg::POS_W-1:0]           in_encoder_raw,
  input  wire logic signed [mft_pkg::SPEED_W-1:0]  in_speed_rpm,
  input  wire logic signed [mft_pkg::CUR_W-1:0]    in_current_raw,
  input  wire logic [mft_pkg::TEMP_W-1:0]          in_temperature_raw,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_link_up,
  output logic signed [mft_pkg::MTP_W-1:0]         out_multi_turn_position,
  output logic signed [mft_pkg::ANGLE_W-1:0]       out_angle_q16,
  output logic signed [mft_pkg::SPQ_W-1:0]         out_speed_q16,
  output logic signed [mft_pkg::CUR_W-1:0]         out_current_out,
  output logic [mft_pkg::TEMP_W-1:0]               out_temperature_out
);
  import mft_pkg::*;

  logic [MTP_W-1:0]  pos_offset_r;
  logic [GAIN_W-1:0] speed_gain_r;
  logic              trk_valid;
  logic              trk_ready;
  trk_state_t        trk_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_offset_r <= '0;
      speed_gain_r <= SPEED_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_OFFSET: pos_offset_r <= cfg_wdata[MTP_W-1:0];
        CFG_SPEED_GAIN: speed_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mft_tracker u_tracker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_encoder_raw     (in_encoder_raw),
    .in_speed_rpm       (in_speed_rpm),
    .in_current_raw     (in_current_raw),
    .in_temperature_raw (in_temperature_raw),
    .trk_valid          (trk_valid),
    .trk_ready          (trk_ready),
    .trk_state          (trk_state)
  );

  mft_scale u_scale (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .pos_offset              (pos_offset_r),
    .speed_gain              (speed_gain_r),
    .trk_valid               (trk_valid),
    .trk_ready               (trk_ready),
    .trk_state               (trk_state),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_link_up             (out_link_up),
    .out_multi_turn_position (out_multi_turn_position),
    .out_angle_q16           (out_angle_q16),
    .out_speed_q16           (out_speed_q16),
    .out_current_out         (out_current_out),
    .out_temperature_out     (out_temperature_out)
  );

endmodule
`default_nettype wire

### src/mft_tracker.sv
`default_nettype none
module mft_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cmd,
  input  wire logic [mft_pkg::POS_W-1:0]      in_encoder_raw,
  input  wire logic signed [mft_pkg::SPEED_W-1:0] in_speed_rpm,
  input  wire logic signed [mft_pkg::CUR_W-1:0]   in_current_raw,
  input  wire logic [mft_pkg::TEMP_W-1:0]     in_temperature_raw,
  output logic                                trk_valid,
  input  wire logic                           trk_ready,
  output mft_pkg::trk_state_t                 trk_state
);
  import mft_pkg::*;

  localparam logic signed [POS_W:0] HALF_POS = (POS_W+1)'(HALF_REV);

  trk_state_t        st_r;
  trk_state_t        st_nxt;
  logic              seen_r;
  logic              seen_nxt;
  logic              valid_r;
  logic              accept;
  logic signed [POS_W:0] delta;

  assign in_stall  = valid_r && !trk_ready;
  assign accept    = in_valid && !in_stall;
  assign trk_valid = valid_r;
  assign trk_state = st_r;

  assign delta = $signed({1'b0, in_encoder_raw}) - $signed({1'b0, st_r.last_pos});

  always_comb begin
    st_nxt   = st_r;
    seen_nxt = seen_r;
    if (in_cmd == CMD_FRAME) begin
      if (delta < -HALF_POS) begin
        st_nxt.turns = st_r.turns + TURN_W'(1);
      end else if (delta > HALF_POS) begin
        st_nxt.turns = st_r.turns - TURN_W'(1);
      end
      st_nxt.last_pos = in_encoder_raw;
      st_nxt.speed    = in_speed_rpm;
      st_nxt.current  = in_current_raw;
      st_nxt.temp     = in_temperature_raw;
      seen_nxt        = 1'b1;
    end else begin
      st_nxt.link = seen_r;
      seen_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      seen_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (!valid_r || trk_ready) begin
        valid_r <= accept;
      end
      if (accept) begin
        st_r   <= st_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### src/mft_scale.sv
`default_nettype none
module mft_scale (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [mft_pkg::MTP_W-1:0]          pos_offset,
  input  wire logic [mft_pkg::GAIN_W-1:0]         speed_gain,
  input  wire logic                               trk_valid,
  output logic                                    trk_ready,
  input  wire mft_pkg::trk_state_t                trk_state,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_link_up,
  output logic signed [mft_pkg::MTP_W-1:0]        out_multi_turn_position,
  output logic signed [mft_pkg::ANGLE_W-1:0]      out_angle_q16,
  output logic signed [mft_pkg::SPQ_W-1:0]        out_speed_q16,
  output logic signed [mft_pkg::CUR_W-1:0]        out_current_out,
  output logic [mft_pkg::TEMP_W-1:0]              out_temperature_out
);
  import mft_pkg::*;

  localparam logic signed [ANGLE_SCALE_W-1:0] SCALE = ANGLE_SCALE_W'(ANGLE_SCALE);

  logic                      s2_valid_r;
  logic                      s2_link_r;
  logic [MTP_W-1:0]          s2_pos_r;
  logic [MTP_W-1:0]          s2_pos_nxt;
  logic signed [SPQ_W-1:0]   s2_speed_r;
  logic signed [SPEED_W+GAIN_W:0] speed_prod;
  logic signed [CUR_W-1:0]   s2_cur_r;
  logic [TEMP_W-1:0]         s2_temp_r;

  logic                      out_valid_r;
  logic                      out_link_r;
  logic [MTP_W-1:0]          out_pos_r;
  logic signed [ANGLE_W-1:0] out_angle_r;
  logic signed [ANGLE_W-1:0] angle_nxt;
  logic signed [SPQ_W-1:0]   out_speed_r;
  logic signed [CUR_W-1:0]   out_cur_r;
  logic [TEMP_W-1:0]         out_temp_r;
  logic signed [ANGLE_PROD_W-1:0] angle_prod;
  logic signed [ANGLE_PROD_W-1:0] angle_shift;

  logic out_adv;
  logic s2_adv;

  assign out_adv   = !out_valid_r || !out_stall;
  assign s2_adv    = !s2_valid_r || out_adv;
  assign trk_ready = s2_adv;

  assign s2_pos_nxt = {trk_state.turns[TURN_W-POS_W-1:0], trk_state.last_pos} + pos_offset;
  assign speed_prod = trk_state.speed * $signed({1'b0, speed_gain});

  assign angle_prod  = $signed(s2_pos_r) * SCALE;
  assign angle_shift = angle_prod >>> POS_W;
  assign angle_nxt   = angle_shift[ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_valid_r <= trk_valid;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && trk_valid) begin
      s2_link_r  <= trk_state.link;
      s2_pos_r   <= s2_pos_nxt;
      s2_speed_r <= speed_prod[SPQ_W-1:0];
      s2_cur_r   <= trk_state.current;
      s2_temp_r  <= trk_state.temp;
    end
    if (out_adv && s2_valid_r) begin
      out_link_r  <= s2_link_r;
      out_pos_r   <= s2_pos_r;
      out_angle_r <= angle_nxt;
      out_speed_r <= s2_speed_r;
      out_cur_r   <= s2_cur_r;
      out_temp_r  <= s2_temp_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_link_up             = out_link_r;
  assign out_multi_turn_position = $signed(out_pos_r);
  assign out_angle_q16           = out_angle_r;
  assign out_speed_q16           = out_speed_r;
  assign out_current_out         = out_cur_r;
  assign out_temperature_out     = out_temp_r;

endmodule
`default_nettype wire

### dv/motor_feedback_multiturn_tracker_tb.sv
`default_nettype none
module motor_feedback_multiturn_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mft_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BEATS   = 175;

  typedef struct packed {
    logic                      cmd;
    logic [POS_W-1:0]          enc;
    logic signed [SPEED_W-1:0] speed;
    logic signed [CUR_W-1:0]   current;
    logic [TEMP_W-1:0]         temp;
  } feedback_beat_t;

  typedef struct packed {
    logic                      link;
    logic signed [MTP_W-1:0]   mtp;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [SPQ_W-1:0]   speed;
    logic signed [CUR_W-1:0]   current;
    logic [TEMP_W-1:0]         temp;
  } tracker_reading_t;

  typedef struct packed {
    feedback_beat_t   beat;
    logic             hand_typed;
    tracker_reading_t reading;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_POS_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = CMD_FRAME;
  logic [POS_W-1:0] in_encoder_raw = '0;
  logic signed [SPEED_W-1:0] in_speed_rpm = '0;
  logic signed [CUR_W-1:0] in_current_raw = '0;
  logic [TEMP_W-1:0] in_temperature_raw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_link_up;
  logic signed [MTP_W-1:0] out_multi_turn_position;
  logic signed [ANGLE_W-1:0] out_angle_q16;
  logic signed [SPQ_W-1:0] out_speed_q16;
  logic signed [CUR_W-1:0] out_current_out;
  logic [TEMP_W-1:0] out_temperature_out;

  logic [MTP_W-1:0]          offset_reg;
  logic [GAIN_W-1:0]         gain_reg;
  logic [POS_W-1:0]          pos_hold;
  logic [TURN_W-1:0]         turn_count;
  logic                      frame_seen;
  logic                      link_state;
  logic signed [SPEED_W-1:0] speed_hold;
  logic signed [CUR_W-1:0]   current_hold;
  logic [TEMP_W-1:0]         temp_hold;

  tracker_reading_t pending_readings[$];
  directed_row_t    directed_rows[$];
  logic [POS_W-1:0] stim_enc = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int readings_checked = 0;
  int beats_sent = 0;
  int ticks_sent = 0;
  int turn_moves = 0;

  motor_feedback_multiturn_tracker dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_cmd                  (in_cmd),
    .in_encoder_raw          (in_encoder_raw),
    .in_speed_rpm            (in_speed_rpm),
    .in_current_raw          (in_current_raw),
    .in_temperature_raw      (in_temperature_raw),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_link_up             (out_link_up),
    .out_multi_turn_position (out_multi_turn_position),
    .out_angle_q16           (out_angle_q16),
    .out_speed_q16           (out_speed_q16),
    .out_current_out         (out_current_out),
    .out_temperature_out     (out_temperature_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tracker_reading_t track_feedback(feedback_beat_t b);
    tracker_reading_t r;
    int delta;
    logic [MTP_W-1:0] mtp_bits;
    longint angle_full;
    longint speed_full;
    if (b.cmd == CMD_FRAME) begin
      delta = int'(b.enc) - int'(pos_hold);
      if (delta < -HALF_REV) begin
        turn_count = turn_count + 1;
        turn_moves++;
      end else if (delta > HALF_REV) begin
        turn_count = turn_count - 1;
        turn_moves++;
      end
      pos_hold = b.enc;
      speed_hold = b.speed;
      current_hold = b.current;
      temp_hold = b.temp;
      frame_seen = 1'b1;
    end else begin
      link_state = frame_seen;
      frame_seen = 1'b0;
    end
    mtp_bits = turn_count * 32'(COUNTS_PER_REV) + 32'(pos_hold) + offset_reg;
    angle_full = (longint'($signed(mtp_bits)) * longint'(ANGLE_SCALE)) >>> POS_W;
    speed_full = longint'(speed_hold) * longint'({1'b0, gain_reg});
    r.link = link_state;
    r.mtp = mtp_bits;
    r.angle = angle_full[ANGLE_W-1:0];
    r.speed = speed_full[SPQ_W-1:0];
    r.current = current_hold;
    r.temp = temp_hold;
    return r;
  endfunction

  function automatic feedback_beat_t beat_of(logic cmd, int enc, int spd, int cur, int temp);
    feedback_beat_t b;
    b.cmd = cmd;
    b.enc = enc[POS_W-1:0];
    b.speed = spd[SPEED_W-1:0];
    b.current = cur[CUR_W-1:0];
    b.temp = temp[TEMP_W-1:0];
    return b;
  endfunction

  function automatic tracker_reading_t reading_of(logic link, int mtp, longint angle, int spq,
                                                  int cur, int temp);
    tracker_reading_t r;
    r.link = link;
    r.mtp = mtp;
    r.angle = angle[ANGLE_W-1:0];
    r.speed = spq;
    r.current = cur[CUR_W-1:0];
    r.temp = temp[TEMP_W-1:0];
    return r;
  endfunction

  function automatic directed_row_t known_row(feedback_beat_t b, tracker_reading_t r);
    directed_row_t row;
    row.beat = b;
    row.hand_typed = 1'b1;
    row.reading = r;
    return row;
  endfunction

  function automatic directed_row_t open_row(feedback_beat_t b);
    directed_row_t row;
    row.beat = b;
    row.hand_typed = 1'b0;
    row.reading = '0;
    return row;
  endfunction

  function automatic feedback_beat_t next_beat();
    feedback_beat_t b;
    int pick;
    int step;
    int sum;
    b.cmd = CMD_FRAME;
    b.enc = POS_W'($urandom);
    b.speed = SPEED_W'($urandom);
    b.current = CUR_W'($urandom);
    b.temp = TEMP_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      b.cmd = CMD_TICK;
    end else begin
      if (pick < 80) begin
        step = int'($urandom_range(0, 7000)) - 3500;
      end else begin
        step = $urandom_range(0, 1) ? HALF_REV : HALF_REV + 1;
        if ($urandom_range(0, 1)) step = -step;
      end
      if (pick < 90) begin
        sum = int'(stim_enc) + step;
        b.enc = sum[POS_W-1:0];
      end
      stim_enc = b.enc;
      if ($urandom_range(0, 9) == 0) b.speed = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      if ($urandom_range(0, 9) == 0) b.current = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    end
    return b;
  endfunction

  task automatic send_beat(feedback_beat_t b, logic hand_typed, tracker_reading_t hand);
    tracker_reading_t predicted;
    in_valid <= 1'b1;
    in_cmd <= b.cmd;
    in_encoder_raw <= b.enc;
    in_speed_rpm <= b.speed;
    in_current_raw <= b.current;
    in_temperature_raw <= b.temp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = track_feedback(b);
    pending_readings.push_back(hand_typed ? hand : predicted);
    beats_sent++;
    if (b.cmd == CMD_TICK) ticks_sent++;
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_registers(logic [MTP_W-1:0] offset, logic [GAIN_W-1:0] gain);
    cfg_we <= 1'b1;
    cfg_index <= CFG_POS_OFFSET;
    cfg_wdata <= offset;
    @(posedge clk);
    cfg_index <= CFG_SPEED_GAIN;
    cfg_wdata <= {{(CFG_DATA_W-GAIN_W){1'b0}}, gain};
    @(posedge clk);
    cfg_we <= 1'b0;
    offset_reg = offset;
    gain_reg = gain;
  endtask

  task automatic random_run(logic [MTP_W-1:0] offset, logic [GAIN_W-1:0] gain,
                            int tx_pct, int rx_pct);
    wait_idle();
    load_registers(offset, gain);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (PHASE_BEATS) begin
      send_beat(next_beat(), 1'b0, '0);
      sender_gap();
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin : reading_check
    tracker_reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat expected none actual pos %h", $time,
                 out_multi_turn_position);
      end else begin
        want = pending_readings.pop_front();
        check_field("link_up", want.link, out_link_up);
        check_field("multi_turn_position", want.mtp, out_multi_turn_position);
        check_field("angle_q16", want.angle, out_angle_q16);
        check_field("speed_q16", want.speed, out_speed_q16);
        check_field("current_out", want.current, out_current_out);
        check_field("temperature_out", want.temp, out_temperature_out);
        readings_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    offset_reg = '0;
    gain_reg = SPEED_GAIN_RESET;
    pos_hold = '0;
    turn_count = '0;
    frame_seen = 1'b0;
    link_state = 1'b0;
    speed_hold = '0;
    current_hold = '0;
    temp_hold = '0;

    directed_rows.push_back(known_row(beat_of(CMD_TICK, 0, 0, 0, 0),
                                      reading_of(1'b0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(known_row(beat_of(CMD_FRAME, 0, 0, 0, 0),
                                      reading_of(1'b0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(known_row(beat_of(CMD_TICK, 0, 0, 0, 0),
                                      reading_of(1'b1, 0, 0, 0, 0, 0)));
    directed_rows.push_back(known_row(beat_of(CMD_TICK, 0, 0, 0, 0),
                                      reading_of(1'b0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(known_row(beat_of(CMD_FRAME, 8191, 32767, 32767, 255),
                                      reading_of(1'b0, -1, -51, 224879921, 32767, 255)));
    directed_rows.push_back(known_row(beat_of(CMD_FRAME, 0, -32768, -32768, 0),
                                      reading_of(1'b0, 0, 0, -224886784, -32768, 0)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 4096, 100, -5, 25)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 0, 200, -6, 26)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 4097, 300, -7, 27)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 0, 400, -8, 28)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 1, 500, 9, 29)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 3000, 1500, 10, 30)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 6000, 3000, 11, 31)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 1000, 4500, 12, 32)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 4000, 6000, 13, 33)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 7000, 7500, 14, 34)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 2000, 9000, 15, 35)));
    directed_rows.push_back(open_row(beat_of(CMD_TICK, 5555, 1234, -4321, 77)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 8191, -1, 1, 128)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 4095, -2, 2, 129)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 8191, -3, 3, 130)));
    directed_rows.push_back(open_row(beat_of(CMD_FRAME, 0, -4, 4, 131)));
    directed_rows.push_back(open_row(beat_of(CMD_TICK, 8191, -1, -1, 255)));
    directed_rows.push_back(open_row(beat_of(CMD_TICK, 0, 0, 0, 0)));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 14;
    rx_idle_pct = 77;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].hand_typed, directed_rows[i].reading);
      sender_gap();
    end

    random_run(32'h7fff_f000, 16'hffff, 14, 77);
    random_run(32'h8000_0000, 16'h0000, 14, 77);
    random_run($urandom, GAIN_W'($urandom_range(0, 65535)), 77, 14);
    random_run(32'hffff_ffff, 16'h0001, 77, 14);
    random_run($urandom, GAIN_W'($urandom_range(0, 65535)), 0, 0);
    random_run(32'h0000_0000, SPEED_GAIN_RESET, 0, 0);
    wait_idle();

    $display("Sent %0d beats (%0d watchdog ticks, %0d turn crossings) over seven register settings",
             beats_sent, ticks_sent, turn_moves);
    $display("Compared %0d result beats under mixed sender and receiver idling, %0d mismatches",
             readings_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
